// ===== rtl/mwm_pkg.sv =====
// shared types, widths and constants of the mecanum wheel mixer
package mwm_pkg;

  localparam int CMD_W      = 12;
  localparam int DUTY_W     = 11;
  localparam int TIME_W     = 32;
  localparam int SCALE_W    = 10;
  localparam int TMO_W      = 16;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;
  localparam int NUM_WHEELS = 4;

  // signed wheel sum and its magnitude, up to three full-scale commands
  localparam int SUM_W  = 13;
  localparam int MAG_W  = 12;
  // magnitude times the command limit
  localparam int DVD_W  = 22;
  // normalized wheel magnitude, at most the command limit
  localparam int Q_W    = 10;
  // wheel magnitude times duty scale, in millionths
  localparam int PROD_W = 20;

  localparam int DIV_BPS    = 2;
  localparam int DIV_STAGES = Q_W / DIV_BPS;

  // divide by the command limit as a multiply by a rounded-up reciprocal
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP_W     = 21;
  localparam int RP_W        = PROD_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_K = 21'd1073742;

  localparam int CMD_LIMIT        = 1000;
  localparam int ENABLE_THRESHOLD = 100;
  localparam int TIMEOUT_RESET    = 100;

  typedef logic signed [CMD_W-1:0]  cmd_t;
  typedef logic signed [DUTY_W-1:0] duty_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [TIME_W-1:0]        time_t;
  typedef logic [MAG_W-1:0]         mag_t;
  typedef logic [DVD_W-1:0]         dvd_t;
  typedef logic [Q_W-1:0]           quo_t;
  typedef logic [PROD_W-1:0]        prod_t;

  typedef enum logic {
    REG_DUTY_SCALE  = 1'b0,
    REG_CMD_TIMEOUT = 1'b1
  } reg_idx_t;

  // per-item data that rides alongside the divider
  typedef struct packed {
    logic [NUM_WHEELS-1:0]          neg;
    logic [NUM_WHEELS-1:0][Q_W-1:0] small_mag;
    logic                           scale_on;
    time_t                          expiry;
  } side_t;

  function automatic duty_t sat_cmd(cmd_t x);
    duty_t y;
    if (x > cmd_t'(CMD_LIMIT)) begin
      y = duty_t'(CMD_LIMIT);
    end else if (x < -cmd_t'(CMD_LIMIT)) begin
      y = -duty_t'(CMD_LIMIT);
    end else begin
      y = duty_t'(x);
    end
    return y;
  endfunction

endpackage

// ===== rtl/mwm_div.sv =====
// pipelined restoring divider, two quotient bits per stage
module mwm_div (
  input  logic                            clk,
  input  logic [mwm_pkg::DIV_STAGES-1:0]  en,
  input  mwm_pkg::dvd_t                   dividend,
  input  mwm_pkg::mag_t                   divisor,
  output mwm_pkg::quo_t                   quotient
);
  import mwm_pkg::*;

  dvd_t rem_r   [DIV_STAGES];
  quo_t quo_r   [DIV_STAGES];
  mag_t den_r   [DIV_STAGES];
  dvd_t rem_nxt [DIV_STAGES];
  quo_t quo_nxt [DIV_STAGES];
  dvd_t rem_in  [DIV_STAGES];
  quo_t quo_in  [DIV_STAGES];
  mag_t den_in  [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign rem_in[k] = dividend;
      assign quo_in[k] = '0;
      assign den_in[k] = divisor;
    end else begin : g_next
      assign rem_in[k] = rem_r[k-1];
      assign quo_in[k] = quo_r[k-1];
      assign den_in[k] = den_r[k-1];
    end

    // quotient is known to fit, so each bit is one shifted compare and subtract
    always_comb begin
      dvd_t r;
      quo_t q;
      dvd_t d;
      r = rem_in[k];
      q = quo_in[k];
      for (int s = 0; s < DIV_BPS; s++) begin
        d = dvd_t'(den_in[k]) << (Q_W - 1 - k * DIV_BPS - s);
        if (r >= d) begin
          r = r - d;
          q = q | (quo_t'(1) << (Q_W - 1 - k * DIV_BPS - s));
        end
      end
      rem_nxt[k] = r;
      quo_nxt[k] = q;
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= rem_nxt[k];
        quo_r[k] <= quo_nxt[k];
        den_r[k] <= den_in[k];
      end
    end
  end

  assign quotient = quo_r[DIV_STAGES-1];

endmodule

// ===== rtl/mecanum_wheel_mixer_top.sv =====
// mecanum wheel mixer: pipelined command-to-duty datapath with apb registers
//
// Each input beat (lateral, forward, yaw, time) produces one output beat with four
// wheel duties, four enables and the command expiry. The pipeline is 10 register
// stages deep, and a new beat is taken every cycle while the output side does not
// stall. The stages are the mix, the peak and dividend, the peak normalization
// divider in five stages of two quotient bits each, the duty scale multiply, the
// reciprocal multiply that divides by 1000 and the output register. Each
// stage holds its beat until the next one frees, so bubbles close up under
// backpressure and in_ready stays high while any stage is empty. Registers:
// duty scale at address 0 (reset 1000, values above 1000 act as 1000) and
// command timeout at address 4 (reset 100).
module mecanum_wheel_mixer_top (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_ready,
  input  mwm_pkg::cmd_t                 in_lateral_cmd,
  input  mwm_pkg::cmd_t                 in_forward_cmd,
  input  mwm_pkg::cmd_t                 in_yaw_cmd,
  input  mwm_pkg::time_t                in_time_now,

  output logic                          out_valid,
  input  logic                          out_ready,
  output mwm_pkg::duty_t                out_duty_front_left,
  output mwm_pkg::duty_t                out_duty_front_right,
  output mwm_pkg::duty_t                out_duty_back_left,
  output mwm_pkg::duty_t                out_duty_back_right,
  output logic                          out_enable_front_left,
  output logic                          out_enable_front_right,
  output logic                          out_enable_back_left,
  output logic                          out_enable_back_right,
  output mwm_pkg::time_t                out_expiry_time,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [mwm_pkg::APB_AW-1:0]    paddr,
  input  logic [mwm_pkg::APB_DW-1:0]    pwdata,
  output logic [mwm_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import mwm_pkg::*;

  localparam int NSTG    = DIV_STAGES + 5;
  localparam int DIV_LO  = 2;
  localparam int PROD_ST = DIV_LO + DIV_STAGES;
  localparam int RCP_ST  = PROD_ST + 1;
  localparam int OUT_ST  = RCP_ST + 1;

  // ---------------- configuration registers ----------------
  logic [SCALE_W-1:0] duty_scale_r;
  logic [TMO_W-1:0]   cmd_timeout_r;
  logic [SCALE_W-1:0] scale_eff;
  reg_idx_t           reg_sel;
  logic               cfg_we;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign cfg_we  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_scale_r  <= SCALE_W'(CMD_LIMIT);
      cmd_timeout_r <= TMO_W'(TIMEOUT_RESET);
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_DUTY_SCALE:  duty_scale_r  <= pwdata[SCALE_W-1:0];
        REG_CMD_TIMEOUT: cmd_timeout_r <= pwdata[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_DUTY_SCALE:  prdata = APB_DW'(duty_scale_r);
      REG_CMD_TIMEOUT: prdata = APB_DW'(cmd_timeout_r);
      default:         prdata = '0;
    endcase
  end

  assign scale_eff = (duty_scale_r > SCALE_W'(CMD_LIMIT)) ? SCALE_W'(CMD_LIMIT) : duty_scale_r;

  // ---------------- flow control ----------------
  logic [NSTG-1:0] valid_r;
  logic [NSTG-1:0] en;

  // a stage loads when it is empty or its beat moves on
  always_comb begin
    en[NSTG-1] = !valid_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[0]) begin
        valid_r[0] <= in_valid;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          valid_r[k] <= valid_r[k-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = valid_r[NSTG-1];

  // ---------------- stage 0: saturate, mix, magnitude ----------------
  duty_t                 lat_sat, fwd_sat, yaw_sat;
  sum_t                  w [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] s0_neg_nxt;
  mag_t                  s0_mag_nxt [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] s0_neg_r;
  mag_t                  s0_mag_r [NUM_WHEELS];
  time_t                 s0_exp_r;

  always_comb begin
    sum_t fs, ls, ys;
    lat_sat = sat_cmd(in_lateral_cmd);
    fwd_sat = sat_cmd(in_forward_cmd);
    yaw_sat = sat_cmd(in_yaw_cmd);
    fs = sum_t'(fwd_sat);
    ls = sum_t'(lat_sat);
    ys = sum_t'(yaw_sat);
    w[0] = fs + ls + ys;
    w[1] = fs - ls - ys;
    w[2] = fs - ls + ys;
    w[3] = fs + ls - ys;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      s0_neg_nxt[i] = w[i][SUM_W-1];
      s0_mag_nxt[i] = w[i][SUM_W-1] ? MAG_W'(-w[i]) : MAG_W'(w[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_neg_r <= s0_neg_nxt;
      s0_mag_r <= s0_mag_nxt;
      s0_exp_r <= in_time_now + TIME_W'(cmd_timeout_r);
    end
  end

  // ---------------- stage 1: peak and dividend ----------------
  mag_t  peak_a, peak_b, peak_nxt;
  dvd_t  s1_dvd_nxt [NUM_WHEELS];
  side_t s1_side_nxt;
  dvd_t  s1_dvd_r [NUM_WHEELS];
  mag_t  s1_peak_r;
  side_t s1_side_r;

  always_comb begin
    peak_a   = (s0_mag_r[0] > s0_mag_r[1]) ? s0_mag_r[0] : s0_mag_r[1];
    peak_b   = (s0_mag_r[2] > s0_mag_r[3]) ? s0_mag_r[2] : s0_mag_r[3];
    peak_nxt = (peak_a > peak_b) ? peak_a : peak_b;
    for (int i = 0; i < NUM_WHEELS; i++) begin
      s1_dvd_nxt[i]            = DVD_W'(DVD_W'(s0_mag_r[i]) * DVD_W'(CMD_LIMIT));
      s1_side_nxt.small_mag[i] = s0_mag_r[i][Q_W-1:0];
    end
    s1_side_nxt.neg      = s0_neg_r;
    s1_side_nxt.scale_on = peak_nxt > MAG_W'(CMD_LIMIT);
    s1_side_nxt.expiry   = s0_exp_r;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_dvd_r  <= s1_dvd_nxt;
      s1_peak_r <= peak_nxt;
      s1_side_r <= s1_side_nxt;
    end
  end

  // ---------------- divider stages ----------------
  quo_t  quo [NUM_WHEELS];
  side_t side_r [DIV_STAGES];

  for (genvar i = 0; i < NUM_WHEELS; i++) begin : g_wheel
    mwm_div u_div (
      .clk      (clk),
      .en       (en[PROD_ST-1:DIV_LO]),
      .dividend (s1_dvd_r[i]),
      .divisor  (s1_peak_r),
      .quotient (quo[i])
    );
  end

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_side
    always_ff @(posedge clk) begin
      if (en[DIV_LO+k]) begin
        side_r[k] <= (k == 0) ? s1_side_r : side_r[(k == 0) ? 0 : k-1];
      end
    end
  end

  // ---------------- duty scale multiply ----------------
  side_t                 dsd;
  quo_t                  q_sel [NUM_WHEELS];
  prod_t                 s7_prod_nxt [NUM_WHEELS];
  prod_t                 s7_prod_r [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] s7_neg_r;
  time_t                 s7_exp_r;

  assign dsd = side_r[DIV_STAGES-1];

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      q_sel[i]       = dsd.scale_on ? quo[i] : dsd.small_mag[i];
      s7_prod_nxt[i] = PROD_W'(PROD_W'(q_sel[i]) * PROD_W'(scale_eff));
    end
  end

  always_ff @(posedge clk) begin
    if (en[PROD_ST]) begin
      s7_prod_r <= s7_prod_nxt;
      s7_neg_r  <= dsd.neg;
      s7_exp_r  <= dsd.expiry;
    end
  end

  // ---------------- divide by 1000 and enable ----------------
  logic [RP_W-1:0]       rp [NUM_WHEELS];
  quo_t                  s8_dmag_nxt [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] s8_ena_nxt;
  quo_t                  s8_dmag_r [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] s8_ena_r;
  logic [NUM_WHEELS-1:0] s8_neg_r;
  time_t                 s8_exp_r;

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      rp[i]          = RP_W'(s7_prod_r[i]) * RP_W'(RECIP_K);
      s8_dmag_nxt[i] = rp[i][RECIP_SHIFT +: Q_W];
      s8_ena_nxt[i]  = s7_prod_r[i] > PROD_W'(ENABLE_THRESHOLD);
    end
  end

  always_ff @(posedge clk) begin
    if (en[RCP_ST]) begin
      s8_dmag_r <= s8_dmag_nxt;
      s8_ena_r  <= s8_ena_nxt;
      s8_neg_r  <= s7_neg_r;
      s8_exp_r  <= s7_exp_r;
    end
  end

  // ---------------- output register ----------------
  duty_t                 duty_nxt [NUM_WHEELS];
  duty_t                 duty_r [NUM_WHEELS];
  logic [NUM_WHEELS-1:0] ena_r;
  time_t                 exp_r;

  always_comb begin
    for (int i = 0; i < NUM_WHEELS; i++) begin
      duty_nxt[i] = s8_neg_r[i] ? -duty_t'(DUTY_W'(s8_dmag_r[i])) : duty_t'(DUTY_W'(s8_dmag_r[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en[OUT_ST]) begin
      duty_r <= duty_nxt;
      ena_r  <= s8_ena_r;
      exp_r  <= s8_exp_r;
    end
  end

  assign out_duty_front_left    = duty_r[0];
  assign out_duty_front_right   = duty_r[1];
  assign out_duty_back_left     = duty_r[2];
  assign out_duty_back_right    = duty_r[3];
  assign out_enable_front_left  = ena_r[0];
  assign out_enable_front_right = ena_r[1];
  assign out_enable_back_left   = ena_r[2];
  assign out_enable_back_right  = ena_r[3];
  assign out_expiry_time        = exp_r;

endmodule
